// ----- hw/rtl/c8_pkg.sv -----
// Shared constants, font table, item opcodes and fault codes for the CHIP-8 instruction core.
`default_nettype none
package c8_pkg;

  localparam int MEM_BYTES       = 4096;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int SCREEN_W        = 64;
  localparam int SCREEN_H        = 32;
  localparam int FB_BYTES        = (SCREEN_W * SCREEN_H) / 8;
  localparam int FONT_BYTES      = 80;
  localparam int CTX_DEPTH       = 32;

  localparam logic [11:0] START_DEFAULT = 12'h200;
  localparam logic [15:0] INS_CLS       = 16'h00E0;
  localparam logic [15:0] INS_RET       = 16'h00EE;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_EXEC  = 2'd1,
    OP_FBRD  = 2'd2,
    OP_NONE  = 2'd3
  } item_op_t;

  typedef enum logic [1:0] {
    FLT_OK    = 2'd0,
    FLT_UNDEF = 2'd1,
    FLT_OVER  = 2'd2,
    FLT_UNDER = 2'd3
  } fault_t;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

endpackage
`default_nettype wire

// ----- hw/rtl/c8_fbuf.sv -----
// Framebuffer store with per-byte valid bits, so that a clear resets every byte at once.
`default_nettype none
module c8_fbuf (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       clr,
  input  wire logic       we,
  input  wire logic [7:0] wa,
  input  wire logic [7:0] wd,
  input  wire logic [7:0] ra,
  output logic      [7:0] rdata
);
  import c8_pkg::*;

  logic [7:0]          mem_r [FB_BYTES];
  logic [FB_BYTES-1:0] vld_r;
  logic [7:0]          q_r;
  logic                qv_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    q_r  <= mem_r[ra];
    qv_r <= vld_r[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[wa] <= 1'b1;
    end
  end

  assign rdata = qv_r ? q_r : 8'h00;

endmodule
`default_nettype wire

// ----- hw/rtl/chip8_instruction_core.sv -----
// Top level of the CHIP-8 instruction core: sequencer, memories and stream ports.
//
// One beat on the in_ channel is one item; each item gives exactly one beat on
// the out_ channel. in_tuser selects the item: memory byte write, execute the
// instruction at the PC, framebuffer byte read, or no operation.
// A write item goes straight to the result, a framebuffer read item through a
// read state first. An executed instruction fetches two bytes and makes three
// register reads and a stack read through the single read port of the register
// memory; VF is written after the result where needed, DXYN adds a memory read
// and two framebuffer byte updates per sprite row, FX33 three digit writes and
// FX55 / FX65 a read and a write per register.
// One item is in work at a time; the next is taken as soon as the result is
// loaded into the output register, even if the receiver has not yet taken it.
// While out_tvalid stays high without out_tready the sequencer holds its
// finished result and in_tready stays low.
// After reset a clearing pass over every main memory address loads the font and
// zeroes the rest of main memory and the register file; in_tready stays low during
// it. The framebuffer clears at once. cfg_wr_en writes the start address register.
`default_nettype none
module chip8_instruction_core #(
  parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [11:0] cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // mem_addr[11:0], mem_data[19:12], keys_down[35:20], random_byte[43:36]
  input  wire logic [47:0] in_tdata,
  // opcode[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // pc_now[11:0], redraw[12], sound_on[13], waiting_key[14], read_data[22:15],
  // fault[24:23]
  output logic [31:0]      out_tdata
);
  import c8_pkg::*;

  localparam logic [4:0] SP_MAX = 5'(STACK_DEPTH);

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_FBRD, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6,
    ST_EXEC, ST_VF, ST_DRD, ST_DB0, ST_DB1, ST_DB2, ST_B0, ST_B1, ST_B2,
    ST_S55R, ST_S55W, ST_S65R, ST_S65W, ST_FIN, ST_DONE
  } state_t;

  state_t      state_r;
  logic [11:0] cnt_r;
  logic [11:0] start_r;
  logic [11:0] pc_r, next_r, i_r;
  logic [4:0]  sp_r;
  logic [7:0]  dt_r, st_r;
  logic [7:0]  hi_r;
  logic [15:0] ins_r;
  logic [7:0]  vx_r, vy_r, v0_r;
  logic [11:0] stk_r;
  logic [3:0]  idx_r;
  logic [7:0]  bits_r;
  logic        flag_r;
  logic [11:0] addr_r;
  logic [7:0]  data_r;
  logic [15:0] keys_r;
  logic [7:0]  rnd_r;
  logic        redraw_r, wait_r;
  logic [7:0]  rd_r;
  logic [1:0]  fault_r;
  logic        out_tvalid_r;
  logic [31:0] out_tdata_r;

  logic [7:0]  main_mem_r [MEM_BYTES];
  logic [7:0]  mem_q_r;
  logic        mem_we;
  logic [11:0] mem_wa, mem_ra;
  logic [7:0]  mem_wd;

  logic [11:0] ctx_mem_r [CTX_DEPTH];
  logic [11:0] ctx_q_r;
  logic        ctx_we;
  logic [4:0]  ctx_wa, ctx_ra;
  logic [11:0] ctx_wd;

  logic        fb_clr, fb_we;
  logic [7:0]  fb_wa, fb_wd, fb_ra, fb_q;

  logic        accept;
  logic [3:0]  x, y, n;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic [7:0]  alu_res;
  logic        alu_flag, alu_vf;
  logic [8:0]  sum9;
  logic [12:0] iadd;
  logic [3:0]  key_idx;
  logic        key_any;
  logic [4:0]  sp_m1;
  logic [4:0]  yrow;
  logic [2:0]  xb0, xb1;
  logic [15:0] spr;
  logic [1:0]  bcd_h;
  logic [7:0]  bcd_rem;
  logic [15:0] bcd_mul;
  logic [3:0]  bcd_t, bcd_o;
  logic [11:0] pc2, pc4;

  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;

  assign x   = ins_r[11:8];
  assign y   = ins_r[7:4];
  assign n   = ins_r[3:0];
  assign nn  = ins_r[7:0];
  assign nnn = ins_r[11:0];
  assign pc2 = pc_r + 12'd2;
  assign pc4 = pc_r + 12'd4;
  assign sp_m1 = sp_r - 5'd1;
  assign iadd = {1'b0, i_r} + {5'b0, vx_r};

  always_comb begin
    sum9 = {1'b0, vx_r} + {1'b0, vy_r};
    alu_vf = 1'b1;
    alu_flag = 1'b0;
    alu_res = vy_r;
    case (n)
      4'h0: begin alu_res = vy_r; alu_vf = 1'b0; end
      4'h1: begin alu_res = vx_r | vy_r; alu_vf = 1'b0; end
      4'h2: begin alu_res = vx_r & vy_r; alu_vf = 1'b0; end
      4'h3: begin alu_res = vx_r ^ vy_r; alu_vf = 1'b0; end
      4'h4: begin alu_res = sum9[7:0]; alu_flag = sum9[8]; end
      4'h5: begin alu_res = vx_r - vy_r; alu_flag = (vx_r >= vy_r); end
      4'h6: begin alu_res = {1'b0, vx_r[7:1]}; alu_flag = vx_r[0]; end
      4'h7: begin alu_res = vy_r - vx_r; alu_flag = (vy_r >= vx_r); end
      4'hE: begin alu_res = {vx_r[6:0], 1'b0}; alu_flag = vx_r[7]; end
      default: begin alu_vf = 1'b0; end
    endcase
  end

  always_comb begin
    key_idx = 4'd0;
    key_any = |keys_r;
    for (int k = 15; k >= 0; k--) begin
      if (keys_r[k]) begin
        key_idx = 4'(k);
      end
    end
  end

  always_comb begin
    bcd_h = (vx_r >= 8'd200) ? 2'd2 : (vx_r >= 8'd100) ? 2'd1 : 2'd0;
    bcd_rem = vx_r - ({6'd0, bcd_h} * 8'd100);
    bcd_mul = {8'd0, bcd_rem} * 16'd205;
    bcd_t = bcd_mul[14:11];
    bcd_o = 4'(bcd_rem - ({4'd0, bcd_t} * 8'd10));
  end

  // sprite row placement, wrapped on both axes
  assign yrow = vy_r[4:0] + {1'b0, idx_r};
  assign xb0  = vx_r[5:3];
  assign xb1  = vx_r[5:3] + 3'd1;
  assign spr  = {bits_r, 8'h00} >> vx_r[2:0];

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = data_r;
    mem_ra = pc_r;
    case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = cnt_r;
        mem_wd = (cnt_r < 12'(FONT_BYTES)) ? FONT[cnt_r[6:0]] : 8'h00;
      end
      ST_IDLE: begin
        mem_we = accept && (in_tuser == OP_WRITE);
        mem_wa = in_tdata[11:0];
        mem_wd = in_tdata[19:12];
      end
      ST_F1:  mem_ra = pc_r + 12'd1;
      ST_DRD: mem_ra = i_r + {8'd0, idx_r};
      ST_S65R: mem_ra = i_r + {8'd0, idx_r};
      ST_B0: begin mem_we = 1'b1; mem_wa = i_r; mem_wd = {6'd0, bcd_h}; end
      ST_B1: begin mem_we = 1'b1; mem_wa = i_r + 12'd1; mem_wd = {4'd0, bcd_t}; end
      ST_B2: begin mem_we = 1'b1; mem_wa = i_r + 12'd2; mem_wd = {4'd0, bcd_o}; end
      ST_S55W: begin
        mem_we = 1'b1;
        mem_wa = i_r + {8'd0, idx_r};
        mem_wd = ctx_q_r[7:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    ctx_we = 1'b0;
    ctx_wa = {1'b0, x};
    ctx_wd = '0;
    ctx_ra = 5'd0;
    case (state_r)
      ST_CLR: begin
        ctx_we = (cnt_r < 12'(CTX_DEPTH));
        ctx_wa = cnt_r[4:0];
      end
      ST_F2:   ctx_ra = {1'b0, hi_r[3:0]};
      ST_F3:   ctx_ra = {1'b0, ins_r[7:4]};
      ST_F4:   ctx_ra = 5'd0;
      ST_F5:   ctx_ra = {1'b1, sp_m1[3:0]};
      ST_S55R: ctx_ra = {1'b0, idx_r};
      ST_VF: begin
        ctx_we = 1'b1;
        ctx_wa = 5'd15;
        ctx_wd = {11'd0, flag_r};
      end
      ST_S65W: begin
        ctx_we = 1'b1;
        ctx_wa = {1'b0, idx_r};
        ctx_wd = {4'd0, mem_q_r};
      end
      ST_EXEC: begin
        case (ins_r[15:12])
          4'h2: begin
            ctx_we = (sp_r < SP_MAX);
            ctx_wa = {1'b1, sp_r[3:0]};
            ctx_wd = pc_r;
          end
          4'h6: begin ctx_we = 1'b1; ctx_wd = {4'd0, nn}; end
          4'h7: begin ctx_we = 1'b1; ctx_wd = {4'd0, vx_r + nn}; end
          4'hC: begin ctx_we = 1'b1; ctx_wd = {4'd0, rnd_r & nn}; end
          4'h8: begin
            ctx_we = alu_vf || (n <= 4'h3);
            ctx_wd = {4'd0, alu_res};
          end
          4'hF: begin
            case (nn)
              8'h07: begin ctx_we = 1'b1; ctx_wd = {4'd0, dt_r}; end
              8'h0A: begin ctx_we = key_any; ctx_wd = {8'd0, key_idx}; end
              8'h1E: begin ctx_we = 1'b1; ctx_wa = 5'd15; ctx_wd = {11'd0, iadd[12]}; end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    fb_clr = (state_r == ST_EXEC) && (ins_r == INS_CLS);
    fb_we = 1'b0;
    fb_wa = {yrow, xb0};
    fb_wd = fb_q ^ spr[15:8];
    fb_ra = in_tdata[7:0];
    case (state_r)
      ST_DB0: fb_ra = {yrow, xb0};
      ST_DB1: begin
        fb_we = 1'b1;
        fb_ra = {yrow, xb1};
      end
      ST_DB2: begin
        fb_we = 1'b1;
        fb_wa = {yrow, xb1};
        fb_wd = fb_q ^ spr[7:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      main_mem_r[mem_wa] <= mem_wd;
    end
    mem_q_r <= main_mem_r[mem_ra];
    if (ctx_we) begin
      ctx_mem_r[ctx_wa] <= ctx_wd;
    end
    ctx_q_r <= ctx_mem_r[ctx_ra];
  end

  c8_fbuf u_fbuf (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (fb_clr),
    .we    (fb_we),
    .wa    (fb_wa),
    .wd    (fb_wd),
    .ra    (fb_ra),
    .rdata (fb_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      cnt_r        <= '0;
      start_r      <= START_DEFAULT;
      pc_r         <= START_DEFAULT;
      i_r          <= '0;
      sp_r         <= '0;
      dt_r         <= '0;
      st_r         <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        start_r <= cfg_wr_data;
      end
      if (out_tvalid_r && out_tready && (state_r != ST_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_CLR: begin
          cnt_r <= cnt_r + 12'd1;
          if (cnt_r == 12'(MEM_BYTES - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            addr_r   <= in_tdata[11:0];
            data_r   <= in_tdata[19:12];
            keys_r   <= in_tdata[35:20];
            rnd_r    <= in_tdata[43:36];
            redraw_r <= 1'b0;
            wait_r   <= 1'b0;
            rd_r     <= '0;
            fault_r  <= FLT_OK;
            case (in_tuser)
              OP_EXEC: state_r <= ST_F1;
              OP_FBRD: state_r <= ST_FBRD;
              default: state_r <= ST_DONE;
            endcase
          end
        end
        ST_FBRD: begin
          rd_r    <= fb_q;
          state_r <= ST_DONE;
        end
        ST_F1: begin hi_r <= mem_q_r; state_r <= ST_F2; end
        ST_F2: begin ins_r <= {hi_r, mem_q_r}; state_r <= ST_F3; end
        ST_F3: begin vx_r <= ctx_q_r[7:0]; state_r <= ST_F4; end
        ST_F4: begin vy_r <= ctx_q_r[7:0]; state_r <= ST_F5; end
        ST_F5: begin v0_r <= ctx_q_r[7:0]; state_r <= ST_F6; end
        ST_F6: begin stk_r <= ctx_q_r; state_r <= ST_EXEC; end
        ST_EXEC: begin
          next_r  <= pc2;
          state_r <= ST_FIN;
          idx_r   <= '0;
          flag_r  <= 1'b0;
          case (ins_r[15:12])
            4'h0: begin
              if (ins_r == INS_CLS) begin
                redraw_r <= 1'b1;
              end else if (ins_r == INS_RET) begin
                if (sp_r == 5'd0 || sp_r > SP_MAX) begin
                  fault_r <= FLT_UNDER;
                end else begin
                  sp_r   <= sp_m1;
                  next_r <= stk_r + 12'd2;
                end
              end else begin
                fault_r <= FLT_UNDEF;
              end
            end
            4'h1: next_r <= nnn;
            4'h2: begin
              if (sp_r >= SP_MAX) begin
                fault_r <= FLT_OVER;
              end else begin
                sp_r   <= sp_r + 5'd1;
                next_r <= nnn;
              end
            end
            4'h3: if (vx_r == nn) next_r <= pc4;
            4'h4: if (vx_r != nn) next_r <= pc4;
            4'h5: if (vx_r == vy_r) next_r <= pc4;
            4'h9: if (vx_r != vy_r) next_r <= pc4;
            4'h8: begin
              if (alu_vf) begin
                flag_r  <= alu_flag;
                state_r <= ST_VF;
              end else if (n > 4'h3) begin
                fault_r <= FLT_UNDEF;
              end
            end
            4'hA: i_r <= nnn;
            4'hB: next_r <= nnn + {4'd0, v0_r};
            4'hD: begin
              redraw_r <= 1'b1;
              state_r  <= (n == 4'd0) ? ST_VF : ST_DRD;
            end
            4'hE: begin
              if (nn == 8'h9E) begin
                if (keys_r[vx_r[3:0]]) next_r <= pc4;
              end else if (nn == 8'hA1) begin
                if (!keys_r[vx_r[3:0]]) next_r <= pc4;
              end else begin
                fault_r <= FLT_UNDEF;
              end
            end
            4'hF: begin
              case (nn)
                8'h07: ;
                8'h0A: begin
                  if (!key_any) begin
                    wait_r <= 1'b1;
                    next_r <= pc_r;
                  end
                end
                8'h15: dt_r <= vx_r;
                8'h18: st_r <= vx_r;
                8'h1E: i_r <= iadd[11:0];
                8'h29: i_r <= {8'd0, vx_r[3:0]} * 12'd5;
                8'h33: state_r <= ST_B0;
                8'h55: state_r <= ST_S55R;
                8'h65: state_r <= ST_S65R;
                default: fault_r <= FLT_UNDEF;
              endcase
            end
            default: ;
          endcase
        end
        ST_VF: state_r <= ST_FIN;
        ST_DRD: state_r <= ST_DB0;
        ST_DB0: begin
          bits_r  <= mem_q_r;
          state_r <= ST_DB1;
        end
        ST_DB1: begin
          if ((fb_q & spr[15:8]) != 8'h00) flag_r <= 1'b1;
          state_r <= ST_DB2;
        end
        ST_DB2: begin
          if ((fb_q & spr[7:0]) != 8'h00) flag_r <= 1'b1;
          idx_r <= idx_r + 4'd1;
          state_r <= (idx_r + 4'd1 == n) ? ST_VF : ST_DRD;
        end
        ST_B0: state_r <= ST_B1;
        ST_B1: state_r <= ST_B2;
        ST_B2: state_r <= ST_FIN;
        ST_S55R: state_r <= ST_S55W;
        ST_S65R: state_r <= ST_S65W;
        ST_S55W, ST_S65W: begin
          idx_r <= idx_r + 4'd1;
          if (idx_r == x) begin
            i_r     <= i_r + {8'd0, x} + 12'd1;
            state_r <= ST_FIN;
          end else begin
            state_r <= (state_r == ST_S55W) ? ST_S55R : ST_S65R;
          end
        end
        ST_FIN: begin
          pc_r <= next_r;
          if (!wait_r) begin
            if (dt_r != 8'd0) dt_r <= dt_r - 8'd1;
            if (st_r != 8'd0) st_r <= st_r - 8'd1;
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {7'd0, fault_r, rd_r, wait_r, (st_r != 8'd0), redraw_r, pc_r};
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
